/* rtl/dstwr_pkg.sv */
// Shared types, widths and codes of the two-way ranging responder.
package dstwr_pkg;

   localparam int STAMP_BITS  = 40;
   localparam int HALF_BITS   = (STAMP_BITS + 1) / 2;
   localparam int PROD_BITS   = 2 * STAMP_BITS;
   localparam int SUM_BITS    = STAMP_BITS + 2;
   localparam int FLIGHT_BITS = 41;
   localparam int CNT_BITS    = $clog2(PROD_BITS);
   localparam int MUL_STEPS   = 8;
   localparam int IDLE_BITS   = 17;

   localparam logic [7:0] MSG_POLL  = 8'd0;
   localparam logic [7:0] MSG_RANGE = 8'd2;

   localparam logic [7:0] CSR_OWN_ID      = 8'd0;
   localparam logic [7:0] CSR_IDLE_LIMIT  = 8'd1;
   localparam logic [7:0] CSR_REPLY_DELAY = 8'd2;

   localparam logic [7:0]  OWN_ID_RESET      = 8'd3;
   localparam logic [15:0] IDLE_LIMIT_RESET  = 16'd250;
   localparam logic [15:0] REPLY_DELAY_RESET = 16'd7000;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_SENT   = 2'd1,
      KIND_RECV   = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ACT_POLL_ACK = 2'd0,
      ACT_REPORT   = 2'd1,
      ACT_FAILED   = 2'd2,
      ACT_RESTART  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SENT_NONE   = 2'd0,
      SENT_ACK    = 2'd1,
      SENT_REPORT = 2'd2,
      SENT_FAILED = 2'd3
   } sent_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PREP,
      ST_MUL,
      ST_SUB,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       save_poll;
      logic       save_ack;
      logic       prep;
      logic       mul_step;
      logic       sub;
      logic       div_step;
      logic       load_rsp;
      action_type rsp_action;
      logic [7:0] rsp_sender;
      logic [15:0] rsp_delay;
      logic       rsp_fault;
      logic       rsp_flight;
   } cmd_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] msg_type;
      logic [7:0] target_id;
      logic       mul_done;
      logic       div_done;
      logic       sum_zero;
   } status_type;

endpackage

/* rtl/dstwr_ctrl.sv */
// Controller: protocol state, configuration registers and sequencing of the datapath.
module dstwr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_we,
   input  logic [7:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   input  dstwr_pkg::status_type status,
   output dstwr_pkg::cmd_type    cmd
);

   dstwr_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 await_ff, await_in;
   logic                 broken_ff, broken_in;
   dstwr_pkg::sent_type  last_ff, last_in;
   logic [dstwr_pkg::IDLE_BITS-1:0] idle_ff, idle_in;
   logic [7:0]           own_id_ff;
   logic [15:0]          idle_limit_ff;
   logic [15:0]          reply_delay_ff;

   logic [dstwr_pkg::IDLE_BITS-1:0] idle_inc;
   logic                 slot_free;
   logic                 broken_new;
   logic [7:0]           expected;
   logic                 foreign;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dstwr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign idle_inc  = (idle_ff == {dstwr_pkg::IDLE_BITS{1'b1}}) ? idle_ff : idle_ff + 1'b1;
   assign expected  = await_ff ? dstwr_pkg::MSG_RANGE : dstwr_pkg::MSG_POLL;
   assign broken_new = broken_ff || (status.msg_type != expected);
   assign foreign = ((status.msg_type == dstwr_pkg::MSG_POLL) ||
                     (status.msg_type == dstwr_pkg::MSG_RANGE)) &&
                    (status.target_id != own_id_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dstwr_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         await_ff       <= 1'b0;
         broken_ff      <= 1'b0;
         last_ff        <= dstwr_pkg::SENT_NONE;
         idle_ff        <= '0;
         own_id_ff      <= dstwr_pkg::OWN_ID_RESET;
         idle_limit_ff  <= dstwr_pkg::IDLE_LIMIT_RESET;
         reply_delay_ff <= dstwr_pkg::REPLY_DELAY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         await_ff     <= await_in;
         broken_ff    <= broken_in;
         last_ff      <= last_in;
         idle_ff      <= idle_in;
         if (csr_we) begin
            case (csr_index)
               dstwr_pkg::CSR_OWN_ID:      own_id_ff      <= csr_wdata[7:0];
               dstwr_pkg::CSR_IDLE_LIMIT:  idle_limit_ff  <= csr_wdata;
               dstwr_pkg::CSR_REPLY_DELAY: reply_delay_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      await_in     = await_ff;
      broken_in    = broken_ff;
      last_in      = last_ff;
      idle_in      = idle_ff;
      cmd          = '0;
      cmd.rsp_action = dstwr_pkg::ACT_POLL_ACK;
      cmd.rsp_sender = own_id_ff;

      case (state_ff)
         dstwr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = dstwr_pkg::ST_EVAL;
            end
         end
         dstwr_pkg::ST_EVAL: begin
            if (slot_free) begin
               state_in = dstwr_pkg::ST_IDLE;
               case (status.kind)
                  dstwr_pkg::KIND_TICK: begin
                     if ({1'b0, idle_limit_ff} < idle_inc) begin
                        await_in       = 1'b0;
                        idle_in        = '0;
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_action = dstwr_pkg::ACT_RESTART;
                        cmd.rsp_sender = 8'd0;
                     end else begin
                        idle_in = idle_inc;
                     end
                  end
                  dstwr_pkg::KIND_SENT: begin
                     if (last_ff == dstwr_pkg::SENT_ACK) begin
                        cmd.save_ack = 1'b1;
                        idle_in      = '0;
                     end
                  end
                  dstwr_pkg::KIND_RECV: begin
                     if (!foreign) begin
                        broken_in = broken_new;
                        if (status.msg_type == dstwr_pkg::MSG_POLL) begin
                           broken_in      = 1'b0;
                           cmd.save_poll  = 1'b1;
                           await_in       = 1'b1;
                           last_in        = dstwr_pkg::SENT_ACK;
                           idle_in        = '0;
                           cmd.load_rsp   = 1'b1;
                           cmd.rsp_action = dstwr_pkg::ACT_POLL_ACK;
                           cmd.rsp_delay  = reply_delay_ff;
                        end else if (status.msg_type == dstwr_pkg::MSG_RANGE) begin
                           await_in = 1'b0;
                           idle_in  = '0;
                           if (broken_new) begin
                              last_in        = dstwr_pkg::SENT_FAILED;
                              cmd.load_rsp   = 1'b1;
                              cmd.rsp_action = dstwr_pkg::ACT_FAILED;
                           end else begin
                              last_in  = dstwr_pkg::SENT_REPORT;
                              state_in = dstwr_pkg::ST_PREP;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
               if (cmd.load_rsp) rsp_valid_in = 1'b1;
            end
         end
         dstwr_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = dstwr_pkg::ST_MUL;
         end
         dstwr_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_done) state_in = dstwr_pkg::ST_SUB;
         end
         dstwr_pkg::ST_SUB: begin
            cmd.sub = 1'b1;
            if (status.sum_zero) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_action = dstwr_pkg::ACT_REPORT;
               cmd.rsp_fault  = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = dstwr_pkg::ST_IDLE;
            end else begin
               state_in = dstwr_pkg::ST_DIV;
            end
         end
         dstwr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = dstwr_pkg::ST_FIN;
         end
         dstwr_pkg::ST_FIN: begin
            cmd.load_rsp   = 1'b1;
            cmd.rsp_action = dstwr_pkg::ACT_REPORT;
            cmd.rsp_flight = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = dstwr_pkg::ST_IDLE;
         end
         default: state_in = dstwr_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_fin_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dstwr_pkg::ST_FIN) |-> !rsp_valid_ff)
      else $error("result slot occupied when the range result is ready");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && rsp_valid_ff) |-> rsp_ready)
      else $error("pending result overwritten");
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == dstwr_pkg::ST_EVAL))
      else $error("accepted beat not evaluated next");
`endif

endmodule

/* rtl/dstwr_dp.sv */
// Datapath: captured beat, stored stamps, interval products, divider and result register.
module dstwr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  dstwr_pkg::cmd_type    cmd,
   output dstwr_pkg::status_type status,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_msg_type,
   input  logic [7:0]            req_target_id,
   input  logic [39:0]           req_local_stamp,
   input  logic [39:0]           req_peer_poll_sent,
   input  logic [39:0]           req_peer_ack_received,
   input  logic [39:0]           req_peer_range_sent,
   output logic [1:0]            rsp_action,
   output logic [7:0]            rsp_sender_id,
   output logic [15:0]           rsp_tx_delay_us,
   output logic signed [40:0]    rsp_flight_ticks,
   output logic                  rsp_divide_fault
);

   localparam int SB = dstwr_pkg::STAMP_BITS;
   localparam int HB = dstwr_pkg::HALF_BITS;
   localparam int PB = dstwr_pkg::PROD_BITS;
   localparam int SW = dstwr_pkg::SUM_BITS;
   localparam int FB = dstwr_pkg::FLIGHT_BITS;
   localparam int CB = dstwr_pkg::CNT_BITS;

   dstwr_pkg::kind_type kind_ff;
   logic [7:0]    msg_ff, target_ff;
   logic [SB-1:0] stamp_ff, poll_tx_ff, ack_rx_ff, range_tx_ff;
   logic [SB-1:0] poll_rx_ff, ack_tx_ff;
   logic [SB-1:0] round1_ff, reply1_ff, round2_ff, reply2_ff;
   logic [SW-1:0] sum_ff;
   logic [PB-1:0] acc_ff, pa_ff, num_ff;
   logic [SW-1:0] rem_ff;
   logic [FB-1:0] quo_ff;
   logic          neg_ff;
   logic [CB-1:0] cnt_ff;
   logic [1:0]    action_ff;
   logic [7:0]    sender_ff;
   logic [15:0]   delay_ff;
   logic [FB-1:0] flight_ff;
   logic          fault_ff;

   logic [2*HB-1:0] op_a, op_b;
   logic [HB-1:0]   half_a, half_b;
   logic [2*HB-1:0] pp;
   logic [4*HB-1:0] pp_wide;
   logic [PB-1:0]   acc_sum;
   logic [SW:0]     rem_sh;
   logic            ge;

   always_comb begin
      op_a   = cnt_ff[2] ? (2*HB)'(reply1_ff) : (2*HB)'(round1_ff);
      op_b   = cnt_ff[2] ? (2*HB)'(reply2_ff) : (2*HB)'(round2_ff);
      half_a = cnt_ff[1] ? op_a[2*HB-1:HB] : op_a[HB-1:0];
      half_b = cnt_ff[0] ? op_b[2*HB-1:HB] : op_b[HB-1:0];
      pp     = (2*HB)'(half_a) * (2*HB)'(half_b);
      case (cnt_ff[1:0])
         2'd0:    pp_wide = (4*HB)'(pp);
         2'd1,
         2'd2:    pp_wide = (4*HB)'(pp) << HB;
         2'd3:    pp_wide = (4*HB)'(pp) << (2*HB);
         default: pp_wide = '0;
      endcase
      acc_sum = acc_ff + PB'(pp_wide);
      rem_sh  = {rem_ff, num_ff[PB-1]};
      ge      = (rem_sh >= {1'b0, sum_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= dstwr_pkg::kind_type'(req_kind);
         msg_ff      <= req_msg_type;
         target_ff   <= req_target_id;
         stamp_ff    <= req_local_stamp[SB-1:0];
         poll_tx_ff  <= req_peer_poll_sent[SB-1:0];
         ack_rx_ff   <= req_peer_ack_received[SB-1:0];
         range_tx_ff <= req_peer_range_sent[SB-1:0];
      end
      if (reset) begin
         poll_rx_ff <= '0;
         ack_tx_ff  <= '0;
      end else begin
         if (cmd.save_poll) poll_rx_ff <= stamp_ff;
         if (cmd.save_ack)  ack_tx_ff  <= stamp_ff;
      end
      if (cmd.prep) begin
         round1_ff <= ack_rx_ff - poll_tx_ff;
         reply1_ff <= ack_tx_ff - poll_rx_ff;
         round2_ff <= stamp_ff - ack_tx_ff;
         reply2_ff <= range_tx_ff - ack_rx_ff;
         acc_ff    <= '0;
         cnt_ff    <= '0;
      end
      if (cmd.mul_step) begin
         sum_ff <= SW'(round1_ff) + SW'(round2_ff) + SW'(reply1_ff) + SW'(reply2_ff);
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff[1:0] == 2'd3 && !cnt_ff[2]) begin
            pa_ff  <= acc_sum;
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_sum;
         end
      end
      if (cmd.sub) begin
         neg_ff <= (pa_ff < acc_ff);
         num_ff <= (pa_ff < acc_ff) ? acc_ff - pa_ff : pa_ff - acc_ff;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? SW'(rem_sh - {1'b0, sum_ff}) : SW'(rem_sh);
         quo_ff <= {quo_ff[FB-2:0], ge};
         num_ff <= {num_ff[PB-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         action_ff <= cmd.rsp_action;
         sender_ff <= cmd.rsp_sender;
         delay_ff  <= cmd.rsp_delay;
         fault_ff  <= cmd.rsp_fault;
         if (cmd.rsp_flight) flight_ff <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
         else                flight_ff <= '0;
      end
   end

   assign status.kind      = kind_ff;
   assign status.msg_type  = msg_ff;
   assign status.target_id = target_ff;
   assign status.mul_done  = (cnt_ff == CB'(dstwr_pkg::MUL_STEPS - 1));
   assign status.div_done  = (cnt_ff == CB'(PB - 1));
   assign status.sum_zero  = (sum_ff == '0);

   assign rsp_action       = action_ff;
   assign rsp_sender_id    = sender_ff;
   assign rsp_tx_delay_us  = delay_ff;
   assign rsp_flight_ticks = $signed(flight_ff);
   assign rsp_divide_fault = fault_ff;

endmodule

/* rtl/ds_twr_ranging_responder_core.sv */
// Top level of the double-sided two-way ranging responder.
//
// Input channel (req_*): one beat per event: a millisecond tick, a frame-sent
// report with its transmit stamp, or a received frame with its stamps. The
// block takes a beat only while it is idle; each beat is first captured and
// then evaluated once the output register is free.
// Result channel (rsp_*): at most one beat per input beat, held in an output
// register until the receiver takes it with rsp_ready.
// A tick, a sent report or a frame without arithmetic is evaluated after
// acceptance and any result is registered as it is evaluated; the block takes
// no new beat before it is back in idle and through with the last one.
// A range frame that leads to a report runs a four-step partial-product
// multiplier per product and a restoring divider that retires one quotient bit
// per cycle over the 80-bit numerator; its result is registered in the FIN state
// after the PREP, MUL, SUB and DIV states, or from SUB if the interval sum is zero.
// While a result waits, the block still accepts the next beat; the evaluation
// of that beat waits until the output register is free, so nothing is lost.
// Reset clears the protocol state, the stored stamps and the idle counter and
// loads the configuration defaults: responder id 3, idle limit 250 ms and a
// reply delay of 7000 us. Configuration writes take effect at once.
module ds_twr_ranging_responder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_msg_type,
   input  logic [7:0]         req_target_id,
   input  logic [39:0]        req_local_stamp,
   input  logic [39:0]        req_peer_poll_sent,
   input  logic [39:0]        req_peer_ack_received,
   input  logic [39:0]        req_peer_range_sent,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_action,
   output logic [7:0]         rsp_sender_id,
   output logic [15:0]        rsp_tx_delay_us,
   output logic signed [40:0] rsp_flight_ticks,
   output logic               rsp_divide_fault,
   input  logic               csr_we,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   dstwr_pkg::cmd_type    cmd;
   dstwr_pkg::status_type status;

   // The controller owns the handshakes and the protocol state.
   dstwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stamps, the arithmetic and the result register.
   dstwr_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_msg_type          (req_msg_type),
      .req_target_id         (req_target_id),
      .req_local_stamp       (req_local_stamp),
      .req_peer_poll_sent    (req_peer_poll_sent),
      .req_peer_ack_received (req_peer_ack_received),
      .req_peer_range_sent   (req_peer_range_sent),
      .rsp_action            (rsp_action),
      .rsp_sender_id         (rsp_sender_id),
      .rsp_tx_delay_us       (rsp_tx_delay_us),
      .rsp_flight_ticks      (rsp_flight_ticks),
      .rsp_divide_fault      (rsp_divide_fault)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench of the two-way ranging responder core.
module tb;

   // Clock, reset and block ports.
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic [7:0]         req_msg_type;
   logic [7:0]         req_target_id;
   logic [39:0]        req_local_stamp;
   logic [39:0]        req_peer_poll_sent;
   logic [39:0]        req_peer_ack_received;
   logic [39:0]        req_peer_range_sent;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_action;
   logic [7:0]         rsp_sender_id;
   logic [15:0]        rsp_tx_delay_us;
   logic signed [40:0] rsp_flight_ticks;
   logic               rsp_divide_fault;
   logic               csr_we;
   logic [7:0]         csr_index;
   logic [15:0]        csr_wdata;

   // One expected response beat.
   typedef struct packed {
      dstwr_pkg::action_type action;
      logic [7:0]         sender;
      logic [15:0]        delay;
      logic signed [40:0] flight;
      logic               fault;
   } reply_type;

   reply_type reply_queue[$];
   int        error_count;

   // Shadow copy of the responder's configuration and protocol state.
   logic [7:0]  cfg_own_id;
   logic [15:0] cfg_idle_limit;
   logic [15:0] cfg_reply_delay;
   logic        sh_await_range;
   logic        sh_broken;
   dstwr_pkg::sent_type sh_last_sent;
   logic [39:0] sh_poll_rx;
   logic [39:0] sh_ack_tx;
   logic [16:0] sh_idle;

   // Stamps of the exchange in progress, so random ranges stay meaningful.
   logic [39:0] cur_poll_tx;

   ds_twr_ranging_responder_core uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit: the slowest item is a range computation plus receiver stalls.
   initial begin
      #20000000;
      $display("tb: done, errors");
      $finish;
   end

   // Time of flight from the four wrapped intervals, truncating toward zero.
   function automatic logic [41:0] flight_of(input logic [39:0] poll_tx,
      input logic [39:0] ack_rx, input logic [39:0] range_tx,
      input logic [39:0] range_rx);
      logic [39:0]  round1, reply1, round2, reply2;
      logic [41:0]  sum;
      logic [79:0]  pa, pb, num;
      logic [79:0]  quo;
      logic         neg;
      logic [40:0]  fl;
      round1 = ack_rx - poll_tx;
      reply1 = sh_ack_tx - sh_poll_rx;
      round2 = range_rx - sh_ack_tx;
      reply2 = range_tx - ack_rx;
      sum = {2'b0, round1} + {2'b0, round2} + {2'b0, reply1} + {2'b0, reply2};
      if (sum == 0) return {1'b1, 41'd0};
      pa = {40'd0, round1} * {40'd0, round2};
      pb = {40'd0, reply1} * {40'd0, reply2};
      neg = pa < pb;
      num = neg ? pb - pa : pa - pb;
      quo = num / {38'd0, sum};
      fl = quo[40:0];
      if (neg) fl = -fl;
      return {1'b0, fl};
   endfunction

   // Apply one accepted beat to the shadow state and queue any expected reply.
   task automatic predict_event(input logic [1:0] kind, input logic [7:0] msg,
      input logic [7:0] target, input logic [39:0] stamp, input logic [39:0] p_poll,
      input logic [39:0] p_ack, input logic [39:0] p_range);
      reply_type   r;
      logic [7:0]  want;
      logic [41:0] res;
      r = '0;
      case (kind)
         dstwr_pkg::KIND_TICK: begin
            if (sh_idle != 17'h1ffff) sh_idle = sh_idle + 17'd1;
            if (sh_idle > {1'b0, cfg_idle_limit}) begin
               sh_await_range = 1'b0;
               sh_idle = '0;
               r.action = dstwr_pkg::ACT_RESTART;
               reply_queue.push_back(r);
            end
         end
         dstwr_pkg::KIND_SENT: begin
            if (sh_last_sent == dstwr_pkg::SENT_ACK) begin
               sh_ack_tx = stamp;
               sh_idle = '0;
            end
         end
         dstwr_pkg::KIND_RECV: begin
            if ((msg == dstwr_pkg::MSG_POLL || msg == dstwr_pkg::MSG_RANGE) &&
                target != cfg_own_id) return;
            want = sh_await_range ? dstwr_pkg::MSG_RANGE : dstwr_pkg::MSG_POLL;
            if (msg != want) sh_broken = 1'b1;
            if (msg == dstwr_pkg::MSG_POLL) begin
               sh_broken = 1'b0;
               sh_poll_rx = stamp;
               sh_await_range = 1'b1;
               sh_last_sent = dstwr_pkg::SENT_ACK;
               sh_idle = '0;
               r.action = dstwr_pkg::ACT_POLL_ACK;
               r.sender = cfg_own_id;
               r.delay = cfg_reply_delay;
               reply_queue.push_back(r);
            end else if (msg == dstwr_pkg::MSG_RANGE) begin
               sh_await_range = 1'b0;
               sh_idle = '0;
               r.sender = cfg_own_id;
               if (!sh_broken) begin
                  res = flight_of(p_poll, p_ack, p_range, stamp);
                  r.action = dstwr_pkg::ACT_REPORT;
                  r.flight = res[40:0];
                  r.fault = res[41];
                  sh_last_sent = dstwr_pkg::SENT_REPORT;
               end else begin
                  r.action = dstwr_pkg::ACT_FAILED;
                  sh_last_sent = dstwr_pkg::SENT_FAILED;
               end
               reply_queue.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // Burst and gap shaping of the sender.
   int burst_left;
   int gap_mode;

   // Present one beat, wait for acceptance, then update the prediction.
   // Valid stays high after acceptance; a gap or drain drops it.
   task automatic send_event(input logic [1:0] kind, input logic [7:0] msg,
      input logic [7:0] target, input logic [39:0] stamp, input logic [39:0] p_poll,
      input logic [39:0] p_ack, input logic [39:0] p_range);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_mode == 0) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_msg_type <= msg;
      req_target_id <= target;
      req_local_stamp <= stamp;
      req_peer_poll_sent <= p_poll;
      req_peer_ack_received <= p_ack;
      req_peer_range_sent <= p_range;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_event(kind, msg, target, stamp, p_poll, p_ack, p_range);
   endtask

   // Drop valid, wait for all expected beats, then let a range computation drain.
   task automatic drain;
      req_valid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         dstwr_pkg::CSR_OWN_ID:     cfg_own_id = value[7:0];
         dstwr_pkg::CSR_IDLE_LIMIT: cfg_idle_limit = value;
         default:                   cfg_reply_delay = value;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [39:0] rand_stamp();
      return {8'($urandom_range(0, 255)), $urandom()};
   endfunction

   task automatic send_tick;
      send_event(dstwr_pkg::KIND_TICK, 8'($urandom), 8'($urandom), rand_stamp(),
                 rand_stamp(), rand_stamp(), rand_stamp());
   endtask

   // A well-formed exchange: poll, ack sent, range with consistent stamps.
   task automatic run_exchange(input logic [39:0] spread);
      logic [39:0] poll_rx, ack_tx, ack_rx, range_tx, range_rx, tof;
      tof = 40'($urandom_range(0, 2000));
      cur_poll_tx = rand_stamp();
      poll_rx = rand_stamp();
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, poll_rx,
                 rand_stamp(), rand_stamp(), rand_stamp());
      ack_tx = poll_rx + 40'({$urandom} % spread);
      send_event(dstwr_pkg::KIND_SENT, 8'($urandom), 8'($urandom), ack_tx, rand_stamp(),
                 rand_stamp(), rand_stamp());
      if ($urandom_range(0, 3) == 0) send_tick();
      ack_rx = cur_poll_tx + (ack_tx - poll_rx) + 2 * tof;
      range_tx = ack_rx + 40'({$urandom} % spread);
      range_rx = ack_tx + (range_tx - ack_rx) + 2 * tof;
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, range_rx,
                 cur_poll_tx, ack_rx, range_tx);
   endtask

   // Directed: extremes of the stamps, the zero divisor and negative flight.
   task automatic test_directed;
      // Zero divisor: every stamp zero.
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, 40'd0,
                 '0, '0, '0);
      send_event(dstwr_pkg::KIND_SENT, 8'hff, 8'hff, 40'd0, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, 40'd0,
                 '0, '0, '0);
      // All ones and wrapped intervals.
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, '1, '1, '1, '1);
      send_event(dstwr_pkg::KIND_SENT, 8'h00, 8'h00, '1, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, '0, '1, '0, '1);
      // Large replies against small rounds give a negative flight.
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, 40'd0,
                 '0, '0, '0);
      send_event(dstwr_pkg::KIND_SENT, 8'h00, 8'h00, 40'h80_0000_0000, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id,
                 40'h80_0000_0010, 40'd0, 40'd5, 40'h80_0000_0005);
      // Frames for another responder are ignored.
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, ~cfg_own_id, '0, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, ~cfg_own_id, '0, '0, '0, '0);
      // Range without poll fails; an odd type breaks the sequence.
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, '0, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, 40'd100,
                 '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, 8'hff, 8'h55, '0, '0, '0, '0);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, '1, '1, '1, '1);
      // Unused kind does nothing; a sent report after a range changes nothing.
      send_event(dstwr_pkg::KIND_UNUSED, 8'hff, 8'hff, '1, '1, '1, '1);
      send_event(dstwr_pkg::KIND_SENT, 8'h00, 8'h00, '1, '0, '0, '0);
      run_exchange(40'hff_ffff_ffff);
      drain();
   endtask

   // Idle timeout with small limits, including zero.
   task automatic test_timeout;
      write_reg(dstwr_pkg::CSR_IDLE_LIMIT, 16'd0);
      repeat (3) send_tick();
      drain();
      write_reg(dstwr_pkg::CSR_IDLE_LIMIT, 16'd2);
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_POLL, cfg_own_id, rand_stamp(),
                 '0, '0, '0);
      repeat (4) send_tick();
      send_event(dstwr_pkg::KIND_RECV, dstwr_pkg::MSG_RANGE, cfg_own_id, rand_stamp(),
                 '0, '0, '0);
      drain();
   endtask

   // Random traffic, mostly well-formed exchanges with noise mixed in.
   task automatic test_random(input int count);
      int sel, n;
      n = 0;
      while (n < count) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            run_exchange(($urandom_range(0, 3) == 0) ? 40'hff_ffff_ffff : 40'd200000);
            n = n + 3;
         end else if (sel == 6) begin
            send_tick();
            n = n + 1;
         end else begin
            send_event(2'($urandom_range(0, 3)),
                       ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom),
                       ($urandom_range(0, 1) != 0) ? cfg_own_id : 8'($urandom),
                       rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp());
            n = n + 1;
         end
      end
      drain();
   endtask

   // Sweeps of the registers, the extremes among them.
   task automatic test_settings;
      write_reg(dstwr_pkg::CSR_OWN_ID, 16'h0000);
      write_reg(dstwr_pkg::CSR_REPLY_DELAY, 16'hffff);
      write_reg(dstwr_pkg::CSR_IDLE_LIMIT, 16'd3);
      test_random(400);
      write_reg(dstwr_pkg::CSR_OWN_ID, 16'h00ff);
      write_reg(dstwr_pkg::CSR_REPLY_DELAY, 16'h0000);
      write_reg(dstwr_pkg::CSR_IDLE_LIMIT, 16'hffff);
      test_random(400);
      write_reg(dstwr_pkg::CSR_OWN_ID, 16'($urandom_range(0, 255)));
      write_reg(dstwr_pkg::CSR_REPLY_DELAY, 16'($urandom));
      write_reg(dstwr_pkg::CSR_IDLE_LIMIT, 16'($urandom_range(1, 8)));
      test_random(400);
   endtask

   // Receiver stall pattern, independent of the sender.
   initial begin
      int mode;
      rsp_ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // Sender gap mode changes over the run, leaving some stretches with no gaps.
   initial begin
      gap_mode = 0;
      forever begin
         repeat (500) @(posedge clock);
         gap_mode = $urandom_range(0, 2);
      end
   end

   // Result checker: compare every accepted beat with the oldest expectation.
   always @(posedge clock) begin
      reply_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_queue.size() == 0) begin
            $display("%0t: unexpected beat, action %0d", $time, rsp_action);
            error_count = error_count + 1;
         end else begin
            exp_r = reply_queue.pop_front();
            if (rsp_action !== exp_r.action || rsp_sender_id !== exp_r.sender ||
                rsp_tx_delay_us !== exp_r.delay || rsp_flight_ticks !== exp_r.flight ||
                rsp_divide_fault !== exp_r.fault) begin
               $display("%0t: mismatch expected act %0d id %0d dly %0d tof %0d flt %0d",
                        $time, exp_r.action, exp_r.sender, exp_r.delay, exp_r.flight,
                        exp_r.fault);
               $display("%0t:          actual act %0d id %0d dly %0d tof %0d flt %0d",
                        $time, rsp_action, rsp_sender_id, rsp_tx_delay_us,
                        rsp_flight_ticks, rsp_divide_fault);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      error_count = 0;
      burst_left = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= '0;
      req_msg_type <= '0;
      req_target_id <= '0;
      req_local_stamp <= '0;
      req_peer_poll_sent <= '0;
      req_peer_ack_received <= '0;
      req_peer_range_sent <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cfg_own_id = dstwr_pkg::OWN_ID_RESET;
      cfg_idle_limit = dstwr_pkg::IDLE_LIMIT_RESET;
      cfg_reply_delay = dstwr_pkg::REPLY_DELAY_RESET;
      sh_await_range = 1'b0;
      sh_broken = 1'b0;
      sh_last_sent = dstwr_pkg::SENT_NONE;
      sh_poll_rx = '0;
      sh_ack_tx = '0;
      sh_idle = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_timeout();
      test_settings();
      test_random(400);
      if (error_count == 0 && reply_queue.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
